// File: design/script_lexer_defines.svh
// assertion macros used by the script lexer top level
`ifndef SCRIPT_LEXER_DEFINES_SVH
`define SCRIPT_LEXER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SLX_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SLX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/slx_pkg.sv
// types, constants and keyword table of the script lexer
package slx_pkg;

  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF   = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int KW_COUNT   = 9;
  localparam int KW_MAX_LEN = 8;

  typedef enum logic [4:0] {
    TK_END      = 5'd0,
    TK_NAME     = 5'd1,
    TK_VAR      = 5'd2,
    TK_FUNCTION = 5'd3,
    TK_IF       = 5'd4,
    TK_ELIF     = 5'd5,
    TK_ELSE     = 5'd6,
    TK_FOR      = 5'd7,
    TK_WHILE    = 5'd8,
    TK_BREAK    = 5'd9,
    TK_CONTINUE = 5'd10,
    TK_PLUS     = 5'd11,
    TK_MINUS    = 5'd12,
    TK_MUL      = 5'd13,
    TK_DIV      = 5'd14,
    TK_EQEQ     = 5'd15,
    TK_LE       = 5'd16,
    TK_GE       = 5'd17,
    TK_LT       = 5'd18,
    TK_GT       = 5'd19,
    TK_NE       = 5'd20,
    TK_ASSIGN   = 5'd21,
    TK_INVALID  = 5'd22
  } tok_kind_e;

  typedef enum logic [2:0] {
    PK_NONE = 3'd0,
    PK_NAME = 3'd1,
    PK_LT   = 3'd2,
    PK_GT   = 3'd3,
    PK_EQ   = 3'd4,
    PK_BANG = 3'd5
  } pend_kind_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] ch;
  } in_word_t;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [31:0] token_line;
    logic [31:0] name_offset;
    logic [15:0] name_length;
    logic        run_last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  word0;
    out_word_t  word1;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              has_room;
  } queue_status_t;

  localparam tok_kind_e KW_KIND [KW_COUNT] = '{
    TK_VAR, TK_FUNCTION, TK_IF, TK_ELIF, TK_ELSE, TK_FOR, TK_WHILE, TK_BREAK, TK_CONTINUE
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd8, 4'd2, 4'd4, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8
  };

  // text right-justified, first character in the highest used byte
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    64'("var"), 64'("function"), 64'("if"), 64'("elif"), 64'("else"),
    64'("for"), 64'("while"), 64'("break"), 64'("continue")
  };

  // text holds byte i at [8*i +: 8]; short is set when the name has at most 8 bytes
  function automatic tok_kind_e kw_lookup(input logic [63:0] text, input logic short,
                                          input logic [3:0] len);
    tok_kind_e kind;
    logic      same;
    kind = TK_NAME;
    for (int k = 0; k < KW_COUNT; k++) begin
      same = short && (len == KW_LEN[k]);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[k])) begin
          if (text[8*i +: 8] != KW_STR[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]) begin
            same = 1'b0;
          end
        end
      end
      if (same) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

// File: design/slx_tokenizer.sv
// tokenizer state and per-byte token logic of the script lexer
module slx_tokenizer #(
  parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = slx_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS   = slx_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  slx_pkg::in_word_t in_word_i,
  output slx_pkg::push_t    push_o
);

  localparam int IDX_W     = $clog2(KEYWORD_CHARS);
  localparam int LEN_CMP_W = LENGTH_BITS + 6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  function automatic logic is_lead(input logic [7:0] c);
    return (c == CH_UNDER) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

  function automatic logic is_body(input logic [7:0] c);
    return is_lead(c) || ((c >= CH_DIG_0) && (c <= CH_DIG_9));
  endfunction

  slx_pkg::pend_kind_e    pend_q, pend_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [31:0]            line_q, line_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [7:0]             kwbuf_q [KEYWORD_CHARS];

  logic             kw_we;
  logic [IDX_W-1:0] kw_idx;
  logic [63:0]      kw_text;
  logic             kw_short;

  slx_pkg::tok_kind_e  flush_kind, pair_kind, fr_kind, k_a, k_b;
  slx_pkg::pend_kind_e fr_pend;
  logic                fr_emit, fr_name, fr_lf;
  logic                e_a, e_b;

  logic [OFFSET_BITS+31:0] start_ext;
  logic [LENGTH_BITS+15:0] len_ext;
  logic [7:0]              c;

  assign c = in_word_i.ch;

  always_comb begin
    for (int i = 0; i < slx_pkg::KW_MAX_LEN; i++) begin
      kw_text[8*i +: 8] = kwbuf_q[i];
    end
  end

  assign kw_short = LEN_CMP_W'(len_q) <= LEN_CMP_W'(slx_pkg::KW_MAX_LEN);

  always_comb begin
    case (pend_q)
      slx_pkg::PK_NAME: flush_kind = slx_pkg::kw_lookup(kw_text, kw_short, len_q[3:0]);
      slx_pkg::PK_LT:   flush_kind = slx_pkg::TK_LT;
      slx_pkg::PK_GT:   flush_kind = slx_pkg::TK_GT;
      slx_pkg::PK_EQ:   flush_kind = slx_pkg::TK_ASSIGN;
      default:          flush_kind = slx_pkg::TK_INVALID;
    endcase
    case (pend_q)
      slx_pkg::PK_LT: pair_kind = slx_pkg::TK_LE;
      slx_pkg::PK_GT: pair_kind = slx_pkg::TK_GE;
      slx_pkg::PK_EQ: pair_kind = slx_pkg::TK_EQEQ;
      default:        pair_kind = slx_pkg::TK_NE;
    endcase
  end

  // a byte that starts fresh, with nothing pending
  always_comb begin
    fr_emit = 1'b0;
    fr_kind = slx_pkg::TK_INVALID;
    fr_pend = slx_pkg::PK_NONE;
    fr_name = 1'b0;
    fr_lf   = 1'b0;
    case (c)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF:    fr_lf = 1'b1;
      CH_PLUS:  begin fr_emit = 1'b1; fr_kind = slx_pkg::TK_PLUS;  end
      CH_MINUS: begin fr_emit = 1'b1; fr_kind = slx_pkg::TK_MINUS; end
      CH_STAR:  begin fr_emit = 1'b1; fr_kind = slx_pkg::TK_MUL;   end
      CH_SLASH: begin fr_emit = 1'b1; fr_kind = slx_pkg::TK_DIV;   end
      CH_LT:    fr_pend = slx_pkg::PK_LT;
      CH_GT:    fr_pend = slx_pkg::PK_GT;
      CH_EQ:    fr_pend = slx_pkg::PK_EQ;
      CH_BANG:  fr_pend = slx_pkg::PK_BANG;
      default: begin
        if (is_lead(c)) begin
          fr_name = 1'b1;
          fr_pend = slx_pkg::PK_NAME;
        end else begin
          fr_emit = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    pend_d  = pend_q;
    len_d   = len_q;
    start_d = start_q;
    line_d  = line_q;
    off_d   = off_q;
    kw_we   = 1'b0;
    kw_idx  = len_q[IDX_W-1:0];
    e_a     = 1'b0;
    k_a     = flush_kind;
    e_b     = 1'b0;
    k_b     = fr_kind;
    if (accept_i) begin
      if (in_word_i.req_type) begin
        e_a     = pend_q != slx_pkg::PK_NONE;
        e_b     = 1'b1;
        k_b     = slx_pkg::TK_END;
        pend_d  = slx_pkg::PK_NONE;
        len_d   = '0;
        start_d = '0;
        line_d  = 32'd1;
        off_d   = '0;
      end else begin
        if (off_q != '1) begin
          off_d = off_q + OFFSET_BITS'(1);
        end
        if ((pend_q == slx_pkg::PK_NAME) && is_body(c)) begin
          kw_we = LEN_CMP_W'(len_q) < LEN_CMP_W'(KEYWORD_CHARS);
          if (len_q != '1) begin
            len_d = len_q + LENGTH_BITS'(1);
          end
        end else if ((pend_q != slx_pkg::PK_NAME) && (pend_q != slx_pkg::PK_NONE) &&
                     (c == CH_EQ)) begin
          e_a    = 1'b1;
          k_a    = pair_kind;
          pend_d = slx_pkg::PK_NONE;
        end else begin
          e_a    = pend_q != slx_pkg::PK_NONE;
          e_b    = fr_emit;
          pend_d = fr_pend;
          if (fr_lf && (line_q != '1)) begin
            line_d = line_q + 32'd1;
          end
          if (fr_name) begin
            start_d = off_q;
            len_d   = LENGTH_BITS'(1);
            kw_we   = 1'b1;
            kw_idx  = '0;
          end
        end
      end
    end
  end

  assign start_ext = {32'b0, start_q};
  assign len_ext   = {16'b0, len_q};

  always_comb begin
    push_o.count = {1'b0, e_a} + {1'b0, e_b};

    push_o.word0.token_kind  = e_a ? k_a : k_b;
    push_o.word0.token_line  = line_q;
    push_o.word0.name_offset = '0;
    push_o.word0.name_length = '0;
    push_o.word0.run_last    = !(e_a && e_b);
    if (e_a && (k_a == slx_pkg::TK_NAME)) begin
      push_o.word0.name_offset = start_ext[31:0];
      push_o.word0.name_length = len_ext[15:0];
    end

    push_o.word1.token_kind  = k_b;
    push_o.word1.token_line  = line_q;
    push_o.word1.name_offset = '0;
    push_o.word1.name_length = '0;
    push_o.word1.run_last    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= slx_pkg::PK_NONE;
      len_q   <= '0;
      start_q <= '0;
      line_q  <= 32'd1;
      off_q   <= '0;
    end else begin
      pend_q  <= pend_d;
      len_q   <= len_d;
      start_q <= start_d;
      line_q  <= line_d;
      off_q   <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (kw_we) begin
      kwbuf_q[kw_idx] <= c;
    end
  end

endmodule

// File: design/slx_out_queue.sv
// shifting result queue of the script lexer, takes up to two words a cycle
module slx_out_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slx_pkg::push_t         push_i,
  input  logic                   pop_i,
  output slx_pkg::out_word_t     head_o,
  output slx_pkg::queue_status_t status_o
);

  localparam int DEPTH  = slx_pkg::QUEUE_DEPTH;
  localparam int QCNT_W = slx_pkg::QCNT_W;

  slx_pkg::out_word_t ent_q [DEPTH];
  slx_pkg::out_word_t ent_d [DEPTH];
  logic [QCNT_W-1:0]  count_q, count_d, base;

  always_comb begin
    base = count_q - QCNT_W'(pop_i);
    for (int i = 0; i < DEPTH; i++) begin
      if (pop_i && (i < DEPTH - 1)) begin
        ent_d[i] = ent_q[(i + 1) % DEPTH];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if ((push_i.count != 2'd0) && (QCNT_W'(i) == base)) begin
        ent_d[i] = push_i.word0;
      end
      if ((push_i.count == 2'd2) && (QCNT_W'(i) == base + QCNT_W'(1))) begin
        ent_d[i] = push_i.word1;
      end
    end
    count_d = base + QCNT_W'(push_i.count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o            = ent_q[0];
  assign status_o.count    = count_q;
  assign status_o.has_room = count_q <= QCNT_W'(DEPTH - 2);

endmodule

// File: design/script_lexer.sv
// top level of the script lexer: byte-serial tokenizer with a result queue
//
// input channel: in_valid_i / in_ready_o carry one word per source byte or an
// end-of-input word (req_type set). output channel: out_valid_o / out_ready_i
// carry one token word each; run_last marks the last token caused by an input.
// an input word is decoded in the cycle it is accepted and its tokens (zero,
// one or two) enter the queue at that edge; with an empty queue the first one
// shows on out_word_o in the next cycle.
// throughput is one input word per cycle while in_ready_o is high; the
// four-entry result queue takes two words a cycle and in_ready_o stays high
// while at least two entries are free.
// when the receiver stalls, results wait in the queue in order and in_ready_o
// falls once the queue holds three words, so any input pauses after a stall
// has left three words waiting.
// end of input flushes any pending token, sends an end token and returns the
// lexer to its reset state: line 1, offset 0, nothing pending.
// reset (rst_ni low) empties the queue and clears the same state.
`include "script_lexer_defines.svh"

module script_lexer #(
  parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = slx_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS   = slx_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  slx_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output slx_pkg::out_word_t out_word_o
);

  slx_pkg::push_t         push;
  slx_pkg::queue_status_t q_status;
  logic                   accept;
  logic                   pop;

  assign in_ready_o  = q_status.has_room;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = q_status.count != '0;
  assign pop         = out_valid_o && out_ready_i;

  slx_tokenizer #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .LENGTH_BITS  (LENGTH_BITS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_tokenizer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_word_i(in_word_i),
    .push_o   (push)
  );

  slx_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (out_word_o),
    .status_o(q_status)
  );

  // end of input always leaves an end token queued
  `SLX_ASSERT_NEXT(a_end_gives_word, accept && in_word_i.req_type, out_valid_o, "end word lost")
  // the first of a token pair is always queued together with its partner
  `SLX_ASSERT_IMPL(a_pair_queued, out_valid_o && !out_word_o.run_last, q_status.count >= slx_pkg::QCNT_W'(2), "token pair split")
  // an end token always closes its input
  `SLX_ASSERT_IMPL(a_end_is_last, out_valid_o && (out_word_o.token_kind == slx_pkg::TK_END), out_word_o.run_last, "end token not last")

endmodule

// File: tb/tb_token_checker.sv
// token checker for the script lexer: predicts tokens from accepted words and compares them
module tb_token_checker
  import slx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        err_cnt_o,
  output int        due_cnt_o
);

  localparam int          NAME_CHARS = 8;
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;
  localparam logic [31:0] LINE_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] OFF_MAX    = 32'hFFFF_FFFF;

  string     kw_text [9] = '{"var", "function", "if", "elif", "else",
                             "for", "while", "break", "continue"};
  tok_kind_e kw_tok  [9] = '{TK_VAR, TK_FUNCTION, TK_IF, TK_ELIF, TK_ELSE,
                             TK_FOR, TK_WHILE, TK_BREAK, TK_CONTINUE};

  pend_kind_e  pend;
  logic [7:0]  name_head [NAME_CHARS];
  logic [15:0] name_len;
  logic [31:0] name_start;
  logic [31:0] line_no;
  logic [31:0] offset;

  out_word_t tokens_due [$];
  out_word_t step_tok [2];
  int        step_n;

  function automatic logic is_lead(logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_body(logic [7:0] c);
    return is_lead(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic string show(out_word_t w);
    return $sformatf("kind=%0d line=%0d off=%0d len=%0d last=%0b", w.token_kind,
                     w.token_line, w.name_offset, w.name_length, w.run_last);
  endfunction

  function automatic tok_kind_e name_tok();
    tok_kind_e k;
    logic      same;
    string     s;
    k = TK_NAME;
    if (name_len > NAME_CHARS) return TK_NAME;
    for (int j = 0; j < 9; j++) begin
      s = kw_text[j];
      if (s.len() == int'(name_len)) begin
        same = 1'b1;
        for (int i = 0; i < s.len(); i++) begin
          if (s.getc(i) != name_head[i]) same = 1'b0;
        end
        if (same) k = kw_tok[j];
      end
    end
    return k;
  endfunction

  task automatic emit(tok_kind_e k, logic [31:0] off, logic [15:0] len);
    out_word_t t;
    t.token_kind  = k;
    t.token_line  = line_no;
    t.name_offset = off;
    t.name_length = len;
    t.run_last    = 1'b0;
    step_tok[step_n] = t;
    step_n++;
  endtask

  task automatic flush_pending();
    tok_kind_e k;
    case (pend)
      PK_NAME: begin
        k = name_tok();
        if (k == TK_NAME) emit(k, name_start, name_len);
        else emit(k, '0, '0);
      end
      PK_LT:   emit(TK_LT, '0, '0);
      PK_GT:   emit(TK_GT, '0, '0);
      PK_EQ:   emit(TK_ASSIGN, '0, '0);
      PK_BANG: emit(TK_INVALID, '0, '0);
      default: ;
    endcase
    pend = PK_NONE;
  endtask

  task automatic clear_state();
    pend       = PK_NONE;
    name_len   = '0;
    name_start = '0;
    line_no    = 32'd1;
    offset     = '0;
  endtask

  task automatic lex_word(in_word_t w);
    logic [7:0] c;
    logic       done;
    out_word_t  t;
    step_n = 0;
    c      = w.ch;
    done   = 1'b0;
    if (w.req_type) begin
      flush_pending();
      emit(TK_END, '0, '0);
      clear_state();
    end else begin
      if (pend == PK_NAME) begin
        if (is_body(c)) begin
          if (name_len < NAME_CHARS) name_head[name_len[2:0]] = c;
          if (name_len != LEN_MAX) name_len = name_len + 16'd1;
          done = 1'b1;
        end else begin
          flush_pending();
        end
      end else if (pend != PK_NONE) begin
        if (c == "=") begin
          case (pend)
            PK_LT:   emit(TK_LE, '0, '0);
            PK_GT:   emit(TK_GE, '0, '0);
            PK_EQ:   emit(TK_EQEQ, '0, '0);
            default: emit(TK_NE, '0, '0);
          endcase
          pend = PK_NONE;
          done = 1'b1;
        end else begin
          flush_pending();
        end
      end
      if (!done) begin
        case (c)
          " ", "\t", "\r": ;
          "\n": if (line_no != LINE_MAX) line_no = line_no + 32'd1;
          "+": emit(TK_PLUS, '0, '0);
          "-": emit(TK_MINUS, '0, '0);
          "*": emit(TK_MUL, '0, '0);
          "/": emit(TK_DIV, '0, '0);
          "<": pend = PK_LT;
          ">": pend = PK_GT;
          "=": pend = PK_EQ;
          "!": pend = PK_BANG;
          default: begin
            if (is_lead(c)) begin
              pend         = PK_NAME;
              name_start   = offset;
              name_len     = 16'd1;
              name_head[0] = c;
            end else begin
              emit(TK_INVALID, '0, '0);
            end
          end
        endcase
      end
      if (offset != OFF_MAX) offset = offset + 32'd1;
    end
    for (int i = 0; i < step_n; i++) begin
      t          = step_tok[i];
      t.run_last = (i == step_n - 1);
      tokens_due.insert(tokens_due.size(), t);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      clear_state();
      tokens_due.delete();
      err_cnt_o = 0;
      due_cnt_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) lex_word(in_word_i);
      if (out_valid_i && out_ready_i) begin
        if (tokens_due.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10) $display("unexpected word: got %s", show(out_word_i));
        end else begin
          want = tokens_due.pop_front();
          if (out_word_i !== want) begin
            err_cnt_o++;
            if (err_cnt_o <= 10) begin
              $display("word mismatch: want %s", show(want));
              $display("               got  %s", show(out_word_i));
            end
          end
        end
      end
      due_cnt_o <= tokens_due.size();
    end
  end

endmodule

// File: tb/tb_script_lexer.sv
// testbench top for the script lexer: stimulus, handshake idling and verdict
module tb_script_lexer;
  import slx_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  int        err_cnt;
  int        due_cnt;

  logic quiet;
  int   gap_pct;
  int   sent;

  string kw_list [9] = '{"var", "function", "if", "elif", "else",
                         "for", "while", "break", "continue"};
  string op_list [12] = '{"+", "-", "*", "/", "==", "<=", ">=", "<", ">", "!=", "=", "!"};
  string blanks = " \t\r\n";

  script_lexer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  tb_token_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .err_cnt_o   (err_cnt),
    .due_cnt_o   (due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[script_lexer] ERROR");
    $finish;
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  function automatic logic [7:0] rand_lead();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_body();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'("0" + r);
    return rand_lead();
  endfunction

  task automatic put(logic req, logic [7:0] c);
    if (!quiet && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_word.req_type <= req;
    in_word.ch       <= c;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(1'b0, s.getc(i));
  endtask

  task automatic put_name(int n);
    put(1'b0, rand_lead());
    for (int i = 1; i < n; i++) put(1'b0, rand_body());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_cnt != 0) @(posedge clk);
  endtask

  task automatic rand_token();
    int    r;
    string s;
    r = $urandom_range(0, 39);
    if (r < 8) begin
      put_text(kw_list[$urandom_range(0, 8)]);
    end else if (r < 10) begin
      // near misses of keywords
      s = kw_list[$urandom_range(0, 8)];
      if ($urandom_range(0, 1)) begin
        put_text(s);
        put(1'b0, rand_body());
      end else begin
        put_text(s.substr(0, s.len() - 2));
      end
    end else if (r < 17) begin
      put_name($urandom_range(1, 12));
    end else if (r < 24) begin
      put_text(op_list[$urandom_range(0, 11)]);
    end else if (r < 34) begin
      put(1'b0, blanks.getc($urandom_range(0, 3)));
    end else if (r < 38) begin
      put(1'b0, 8'($urandom));
    end else if (r == 38 && $urandom_range(0, 1) == 0) begin
      put(1'b1, 8'($urandom));
    end else begin
      put(1'b0, " ");
    end
  endtask

  initial begin
    int base;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    quiet    = 1'b0;
    gap_pct  = 0;
    sent     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, every operator, lookahead and flush cases
    gap_pct = 20;
    put(1'b1, 8'h00);
    put(1'b0, 8'h00);
    put(1'b0, 8'hFF);
    put_text("9!x_9\n<=>=<a>\t!===+-*/if=");
    put(1'b1, 8'hFF);
    drain();

    // long name that starts with a keyword
    gap_pct = 2;
    put_text("continue");
    repeat (32) put(1'b0, rand_body());
    put_text("\n");
    put(1'b1, 8'($urandom));
    drain();

    base    = sent;
    gap_pct = 10;
    while (sent - base < 1400) begin
      if (sent - base > 1250) quiet = 1'b1;
      if ($urandom_range(0, 31) == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 40;
        endcase
      end
      rand_token();
    end
    put(1'b1, 8'($urandom));

    quiet = 1'b1;
    drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && due_cnt == 0) begin
      $display("[script_lexer] OK");
    end else begin
      $display("[script_lexer] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/slx_pkg.sv
design/slx_tokenizer.sv
design/slx_out_queue.sv
design/script_lexer.sv
tb/tb_token_checker.sv
tb/tb_script_lexer.sv
